### hdl/nirt_pkg.sv
// Shared types and constants for the NEC infrared frame transmitter.
// Holds the phase encoding, register map, configuration, state and result structs.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package nirt_pkg;

	typedef enum logic [5:0] {
		PH_IDLE       = 6'b000001,
		PH_LEAD_MARK  = 6'b000010,
		PH_LEAD_SPACE = 6'b000100,
		PH_BIT_MARK   = 6'b001000,
		PH_BIT_SPACE  = 6'b010000,
		PH_FINAL_MARK = 6'b100000
	} phase_t;

	localparam int unsigned CfgIndexWidth = 4;
	localparam int unsigned CfgDataWidth  = 12;

	localparam logic [CfgIndexWidth-1:0] REG_ADDRESS_LOW        = 4'd0;
	localparam logic [CfgIndexWidth-1:0] REG_ADDRESS_HIGH       = 4'd1;
	localparam logic [CfgIndexWidth-1:0] REG_CARRIER_HALF_TICKS = 4'd2;
	localparam logic [CfgIndexWidth-1:0] REG_UNIT_TICKS         = 4'd3;
	localparam logic [CfgIndexWidth-1:0] REG_LEADER_MARK_UNITS  = 4'd4;
	localparam logic [CfgIndexWidth-1:0] REG_LEADER_SPACE_UNITS = 4'd5;
	localparam logic [CfgIndexWidth-1:0] REG_BIT_MARK_UNITS     = 4'd6;
	localparam logic [CfgIndexWidth-1:0] REG_ONE_SPACE_UNITS    = 4'd7;

	localparam logic [7:0]  RST_ADDRESS_LOW        = 8'h10;
	localparam logic [7:0]  RST_ADDRESS_HIGH       = 8'h6f;
	localparam logic [7:0]  RST_CARRIER_HALF_TICKS = 8'd13;
	localparam logic [7:0]  RST_UNIT_TICKS         = 8'd8;
	localparam logic [11:0] RST_LEADER_MARK_UNITS  = 12'd1125;
	localparam logic [11:0] RST_LEADER_SPACE_UNITS = 12'd562;
	localparam logic [11:0] RST_BIT_MARK_UNITS     = 12'd70;
	localparam logic [11:0] RST_ONE_SPACE_UNITS    = 12'd210;

	localparam logic [4:0] LAST_BIT = 5'd31;

	typedef struct packed {
		logic [7:0]  address_low;
		logic [7:0]  address_high;
		logic [7:0]  carrier_half_ticks;
		logic [7:0]  unit_ticks;
		logic [11:0] leader_mark_units;
		logic [11:0] leader_space_units;
		logic [11:0] bit_mark_units;
		logic [11:0] one_space_units;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  bit_number;
		logic [31:0] frame_bits;
		logic [7:0]  tick_in_unit;
		logic [11:0] units_left;
		logic [7:0]  carrier_count;
		logic        line_level;
	} state_t;

	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic start_rejected;
		logic frame_done;
	} result_t;

	function automatic logic [7:0] at_least_one8(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	function automatic logic [11:0] at_least_one12(input logic [11:0] v);
		return (v == 12'd0) ? 12'd1 : v;
	endfunction

endpackage

### hdl/nirt_step.sv
// Next-state and result logic for one item of the NEC infrared transmitter.
// Purely combinational; uses the types and helpers of nirt_pkg.
`timescale 1ns / 1ps

module nirt_step (
	input  nirt_pkg::cfg_t    cfg,
	input  nirt_pkg::state_t  st,
	input  logic              kind,
	input  logic [7:0]        command,
	output nirt_pkg::state_t  nxt,
	output nirt_pkg::result_t res
);

	logic                seg_go;
	nirt_pkg::phase_t    seg_phase;
	logic [11:0]         seg_units;
	logic                fin;
	logic                mark;
	logic [7:0]          cc_n;
	logic [7:0]          tick_n;

	always_comb begin
		nxt       = st;
		seg_go    = 1'b0;
		seg_phase = nirt_pkg::PH_IDLE;
		seg_units = 12'd0;
		fin       = 1'b0;
		mark      = st.phase inside {nirt_pkg::PH_LEAD_MARK, nirt_pkg::PH_BIT_MARK,
			nirt_pkg::PH_FINAL_MARK};
		cc_n      = st.carrier_count + 8'd1;
		tick_n    = st.tick_in_unit + 8'd1;
		res       = '0;

		if (kind) begin
			if (st.phase != nirt_pkg::PH_IDLE) begin
				res.start_rejected = 1'b1;
			end else begin
				nxt.frame_bits = {~command, command, cfg.address_high, cfg.address_low};
				nxt.bit_number = 5'd0;
				seg_go         = 1'b1;
				seg_phase      = nirt_pkg::PH_LEAD_MARK;
				seg_units      = cfg.leader_mark_units;
			end
		end else if (st.phase != nirt_pkg::PH_IDLE) begin
			if (mark) begin
				// A counter that wraps to zero also counts as a toggle point.
				if (cc_n >= nirt_pkg::at_least_one8(cfg.carrier_half_ticks) || cc_n == 8'd0) begin
					nxt.carrier_count = 8'd0;
					nxt.line_level    = ~st.line_level;
				end else begin
					nxt.carrier_count = cc_n;
				end
			end else begin
				nxt.line_level = 1'b0;
			end

			if (tick_n >= nirt_pkg::at_least_one8(cfg.unit_ticks) || tick_n == 8'd0) begin
				nxt.tick_in_unit = 8'd0;
				if (st.units_left <= 12'd1) begin
					case (st.phase)
						nirt_pkg::PH_LEAD_MARK: begin
							seg_go    = 1'b1;
							seg_phase = nirt_pkg::PH_LEAD_SPACE;
							seg_units = cfg.leader_space_units;
						end
						nirt_pkg::PH_LEAD_SPACE: begin
							nxt.bit_number = 5'd0;
							seg_go         = 1'b1;
							seg_phase      = nirt_pkg::PH_BIT_MARK;
							seg_units      = cfg.bit_mark_units;
						end
						nirt_pkg::PH_BIT_MARK: begin
							seg_go    = 1'b1;
							seg_phase = nirt_pkg::PH_BIT_SPACE;
							seg_units = st.frame_bits[st.bit_number] ? cfg.one_space_units
								: cfg.bit_mark_units;
						end
						nirt_pkg::PH_BIT_SPACE: begin
							seg_go    = 1'b1;
							seg_units = cfg.bit_mark_units;
							if (st.bit_number == nirt_pkg::LAST_BIT) begin
								seg_phase = nirt_pkg::PH_FINAL_MARK;
							end else begin
								nxt.bit_number = st.bit_number + 5'd1;
								seg_phase      = nirt_pkg::PH_BIT_MARK;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end else begin
					nxt.units_left = st.units_left - 12'd1;
				end
			end else begin
				nxt.tick_in_unit = tick_n;
			end
		end

		if (seg_go) begin
			nxt.phase         = seg_phase;
			nxt.units_left    = nirt_pkg::at_least_one12(seg_units);
			nxt.tick_in_unit  = 8'd0;
			nxt.carrier_count = 8'd0;
			nxt.line_level    = 1'b0;
		end
		if (fin) begin
			nxt.phase         = nirt_pkg::PH_IDLE;
			nxt.units_left    = 12'd0;
			nxt.tick_in_unit  = 8'd0;
			nxt.carrier_count = 8'd0;
			nxt.line_level    = 1'b0;
		end

		res.ir_level   = nxt.line_level;
		res.busy_res   = (nxt.phase != nirt_pkg::PH_IDLE);
		res.frame_done = fin;
	end

endmodule

### hdl/nec_ir_frame_transmitter.sv
// Top level of the NEC infrared frame transmitter: registers, handshakes, assertions.
// Depends on nirt_pkg and instantiates nirt_step.
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   kind, command
// out      output     out_valid / out_stall ir_level, busy_res, start_rejected, frame_done
// cfg      input      cfg_we                cfg_index, cfg_data
//
// One item per clock while out_stall is low: the frame state register and the
// result register are updated in the same cycle an item is accepted, so the
// result appears in the next cycle. The single result register sets the rate;
// it is refilled in the cycle it is taken. Reset returns to idle with the default registers.
// in_stall is raised only while a result is held by out_stall.

module nec_ir_frame_transmitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  command,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ir_level,
	output logic        busy_res,
	output logic        start_rejected,
	output logic        frame_done,
	input  logic        cfg_we,
	input  logic [nirt_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [nirt_pkg::CfgDataWidth-1:0]  cfg_data
);

	nirt_pkg::cfg_t    cfg_q;
	nirt_pkg::state_t  st_q;
	nirt_pkg::state_t  st_nxt;
	nirt_pkg::result_t res_nxt;
	nirt_pkg::result_t res_q;
	logic              out_valid_q;
	logic              in_accept;

	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address_low        <= nirt_pkg::RST_ADDRESS_LOW;
			cfg_q.address_high       <= nirt_pkg::RST_ADDRESS_HIGH;
			cfg_q.carrier_half_ticks <= nirt_pkg::RST_CARRIER_HALF_TICKS;
			cfg_q.unit_ticks         <= nirt_pkg::RST_UNIT_TICKS;
			cfg_q.leader_mark_units  <= nirt_pkg::RST_LEADER_MARK_UNITS;
			cfg_q.leader_space_units <= nirt_pkg::RST_LEADER_SPACE_UNITS;
			cfg_q.bit_mark_units     <= nirt_pkg::RST_BIT_MARK_UNITS;
			cfg_q.one_space_units    <= nirt_pkg::RST_ONE_SPACE_UNITS;
		end else if (cfg_we) begin
			case (cfg_index)
				nirt_pkg::REG_ADDRESS_LOW:        cfg_q.address_low        <= cfg_data[7:0];
				nirt_pkg::REG_ADDRESS_HIGH:       cfg_q.address_high       <= cfg_data[7:0];
				nirt_pkg::REG_CARRIER_HALF_TICKS: cfg_q.carrier_half_ticks <= cfg_data[7:0];
				nirt_pkg::REG_UNIT_TICKS:         cfg_q.unit_ticks         <= cfg_data[7:0];
				nirt_pkg::REG_LEADER_MARK_UNITS:  cfg_q.leader_mark_units  <= cfg_data;
				nirt_pkg::REG_LEADER_SPACE_UNITS: cfg_q.leader_space_units <= cfg_data;
				nirt_pkg::REG_BIT_MARK_UNITS:     cfg_q.bit_mark_units     <= cfg_data;
				nirt_pkg::REG_ONE_SPACE_UNITS:    cfg_q.one_space_units    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	nirt_step u_step (
		.cfg     (cfg_q),
		.st      (st_q),
		.kind    (kind),
		.command (command),
		.nxt     (st_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= nirt_pkg::PH_IDLE;
			st_q.bit_number    <= 5'd0;
			st_q.frame_bits    <= 32'd0;
			st_q.tick_in_unit  <= 8'd0;
			st_q.units_left    <= 12'd0;
			st_q.carrier_count <= 8'd0;
			st_q.line_level    <= 1'b0;
			out_valid_q        <= 1'b0;
		end else if (in_accept) begin
			st_q        <= st_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload needs no reset; it is qualified by out_valid_q.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign ir_level       = res_q.ir_level;
	assign busy_res       = res_q.busy_res;
	assign start_rejected = res_q.start_rejected;
	assign frame_done     = res_q.frame_done;

	// The line is never driven high while no frame is in progress.
	a_idle_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == nirt_pkg::PH_IDLE) |-> !st_q.line_level)
		else $error("line high while idle");

	// A finished frame leaves the block idle in the same item.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.frame_done) |-> !res_q.busy_res && !res_q.ir_level)
		else $error("frame_done while still busy");

	// A rejected start is only reported while a frame goes on.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.start_rejected) |-> res_q.busy_res && !res_q.frame_done)
		else $error("start rejected while idle");

	// An accepted item always produces a result in the next cycle.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid_q)
		else $error("accepted item produced no result");

	// A held result keeps the frame state frozen.
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(st_q))
		else $error("state moved while stalled");

endmodule

### bench/nec_ir_frame_transmitter_tb.sv
// Self-checking bench for the NEC infrared frame transmitter: drives ticks and start items,
// predicts results from its own frame state copy or a table, and compares field by field.
// Depends on nirt_pkg and nec_ir_frame_transmitter.
`timescale 1ns / 1ps

module nec_ir_frame_transmitter_tb;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	localparam logic [nirt_pkg::CfgIndexWidth-1:0] REG_SPARE_FIRST = 4'd8;
	localparam logic [nirt_pkg::CfgIndexWidth-1:0] REG_SPARE_LAST  = 4'd15;

	localparam int GAP_MAX        = 12;
	localparam int RANDOM_ITEMS   = 780;
	localparam int SQUEEZE_CYCLES = 400;

	typedef struct packed {
		logic              kind;
		logic [7:0]        cmd;
		logic              known;
		nirt_pkg::result_t want;
	} probe_row_t;

	// Opening items start from reset with only the leader burst shortened. Known results
	// are written as {ir_level, busy_res, start_rejected, frame_done}; the others are predicted.
	localparam probe_row_t OPENING [21] = '{
		'{KIND_TICK,  8'h00, 1'b1, 4'b0000},
		'{KIND_START, 8'h00, 1'b1, 4'b0100},
		'{KIND_START, 8'hff, 1'b1, 4'b0110},
		'{KIND_TICK,  8'hff, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h01, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h80, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h5a, 1'b0, 4'b0000},
		'{KIND_TICK,  8'ha5, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_START, 8'ha5, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000},
		'{KIND_TICK,  8'h00, 1'b0, 4'b0000}
	};

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic                               kind;
	logic [7:0]                         command;
	logic                               out_valid;
	logic                               out_stall;
	logic                               ir_level;
	logic                               busy_res;
	logic                               start_rejected;
	logic                               frame_done;
	logic                               cfg_we;
	logic [nirt_pkg::CfgIndexWidth-1:0] cfg_index;
	logic [nirt_pkg::CfgDataWidth-1:0]  cfg_data;

	// Predicted transmitter state and register copy.
	nirt_pkg::cfg_t   regs;
	nirt_pkg::phase_t seg_phase;
	logic [4:0]       bit_idx;
	logic [31:0]      frame_word;
	logic [7:0]       tick_cnt;
	logic [11:0]      units_rem;
	logic [7:0]       carrier_cnt;
	logic             ir_line;

	nirt_pkg::result_t expected_levels[$];

	int mismatches      = 0;
	int results_seen    = 0;
	int frames_sent     = 0;
	int starts_rejected = 0;
	int reg_writes      = 0;
	int random_items    = 0;
	bit send_calm       = 1'b0;
	bit recv_calm       = 1'b0;
	bit squeeze_req     = 1'b0;
	bit squeeze_done    = 1'b0;

	always #5 clk = ~clk;

	nec_ir_frame_transmitter dut (.*);

	function automatic int draw_gap(input bit calm);
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	function automatic logic [nirt_pkg::CfgDataWidth-1:0] pick_value(
		input logic [nirt_pkg::CfgIndexWidth-1:0] idx);
		logic [3:0] junk;
		junk = 4'($urandom);
		// Upper data bits are junk for the byte-wide registers and must be dropped.
		case (idx)
			nirt_pkg::REG_ADDRESS_LOW, nirt_pkg::REG_ADDRESS_HIGH: return 12'($urandom);
			nirt_pkg::REG_CARRIER_HALF_TICKS: begin
				case ($urandom_range(0, 7))
					0: return {junk, 8'd0};
					1: return {junk, 8'd255};
					default: return {junk, 8'($urandom_range(1, 6))};
				endcase
			end
			nirt_pkg::REG_UNIT_TICKS:
				return {junk, ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 3))};
			nirt_pkg::REG_LEADER_MARK_UNITS, nirt_pkg::REG_LEADER_SPACE_UNITS,
			nirt_pkg::REG_BIT_MARK_UNITS, nirt_pkg::REG_ONE_SPACE_UNITS:
				return ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(1, 2));
			default: return 12'($urandom);
		endcase
	endfunction

	task automatic open_segment(input nirt_pkg::phase_t ph, input logic [11:0] units);
		seg_phase   = ph;
		units_rem   = (units == 12'd0) ? 12'd1 : units;
		tick_cnt    = 8'd0;
		carrier_cnt = 8'd0;
		ir_line     = 1'b0;
	endtask

	task automatic close_segment(output logic done);
		done = 1'b0;
		case (seg_phase)
			nirt_pkg::PH_LEAD_MARK:
				open_segment(nirt_pkg::PH_LEAD_SPACE, regs.leader_space_units);
			nirt_pkg::PH_LEAD_SPACE: begin
				bit_idx = 5'd0;
				open_segment(nirt_pkg::PH_BIT_MARK, regs.bit_mark_units);
			end
			nirt_pkg::PH_BIT_MARK: open_segment(nirt_pkg::PH_BIT_SPACE,
				frame_word[bit_idx] ? regs.one_space_units : regs.bit_mark_units);
			nirt_pkg::PH_BIT_SPACE: begin
				if (bit_idx == nirt_pkg::LAST_BIT) begin
					open_segment(nirt_pkg::PH_FINAL_MARK, regs.bit_mark_units);
				end else begin
					bit_idx = bit_idx + 5'd1;
					open_segment(nirt_pkg::PH_BIT_MARK, regs.bit_mark_units);
				end
			end
			default: begin
				open_segment(nirt_pkg::PH_IDLE, 12'd0);
				units_rem = 12'd0;
				done      = 1'b1;
			end
		endcase
	endtask

	task automatic predict_item(input logic k, input logic [7:0] cmd,
		output nirt_pkg::result_t r);
		logic       in_mark;
		logic       done;
		logic [7:0] half;
		logic [7:0] unit;
		r    = '0;
		done = 1'b0;
		half = (regs.carrier_half_ticks == 8'd0) ? 8'd1 : regs.carrier_half_ticks;
		unit = (regs.unit_ticks == 8'd0) ? 8'd1 : regs.unit_ticks;
		if (k == KIND_START) begin
			if (seg_phase != nirt_pkg::PH_IDLE) begin
				r.start_rejected = 1'b1;
				starts_rejected++;
			end else begin
				frame_word = {~cmd, cmd, regs.address_high, regs.address_low};
				bit_idx    = 5'd0;
				open_segment(nirt_pkg::PH_LEAD_MARK, regs.leader_mark_units);
			end
		end else if (seg_phase != nirt_pkg::PH_IDLE) begin
			in_mark = seg_phase == nirt_pkg::PH_LEAD_MARK ||
				seg_phase == nirt_pkg::PH_BIT_MARK || seg_phase == nirt_pkg::PH_FINAL_MARK;
			if (in_mark) begin
				carrier_cnt = carrier_cnt + 8'd1;
				if (carrier_cnt >= half || carrier_cnt == 8'd0) begin
					carrier_cnt = 8'd0;
					ir_line     = ~ir_line;
				end
			end else begin
				ir_line = 1'b0;
			end
			tick_cnt = tick_cnt + 8'd1;
			if (tick_cnt >= unit || tick_cnt == 8'd0) begin
				tick_cnt = 8'd0;
				if (units_rem <= 12'd1)
					close_segment(done);
				else
					units_rem = units_rem - 12'd1;
			end
		end
		r.ir_level   = ir_line;
		r.busy_res   = seg_phase != nirt_pkg::PH_IDLE;
		r.frame_done = done;
		if (done)
			frames_sent++;
	endtask

	task automatic send_item(input logic k, input logic [7:0] cmd, input logic known,
		input nirt_pkg::result_t want);
		int                gap;
		nirt_pkg::result_t r;
		gap = draw_gap(send_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		command  <= cmd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// Only starts taken while idle and ticks during a frame do any work.
		if ((k == KIND_START) != (seg_phase != nirt_pkg::PH_IDLE))
			random_items++;
		predict_item(k, cmd, r);
		expected_levels.push_back(known ? want : r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_levels.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [nirt_pkg::CfgIndexWidth-1:0] idx,
		input logic [nirt_pkg::CfgDataWidth-1:0] data);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			nirt_pkg::REG_ADDRESS_LOW:        regs.address_low        = data[7:0];
			nirt_pkg::REG_ADDRESS_HIGH:       regs.address_high       = data[7:0];
			nirt_pkg::REG_CARRIER_HALF_TICKS: regs.carrier_half_ticks = data[7:0];
			nirt_pkg::REG_UNIT_TICKS:         regs.unit_ticks         = data[7:0];
			nirt_pkg::REG_LEADER_MARK_UNITS:  regs.leader_mark_units  = data;
			nirt_pkg::REG_LEADER_SPACE_UNITS: regs.leader_space_units = data;
			nirt_pkg::REG_BIT_MARK_UNITS:     regs.bit_mark_units     = data;
			nirt_pkg::REG_ONE_SPACE_UNITS:    regs.one_space_units    = data;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic run_out_frame();
		while (seg_phase != nirt_pkg::PH_IDLE)
			send_item(KIND_TICK, 8'($urandom), 1'b0, '0);
	endtask

	task automatic check_field(input string field, input logic want, input logic got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0b, got %0b", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		nirt_pkg::result_t want;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (expected_levels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item, expected none, got %0b%0b%0b%0b", $time,
					ir_level, busy_res, start_rejected, frame_done);
			end else begin
				want = expected_levels.pop_front();
				check_field("ir_level", want.ir_level, ir_level);
				check_field("busy_res", want.busy_res, busy_res);
				check_field("start_rejected", want.start_rejected, start_rejected);
				check_field("frame_done", want.frame_done, frame_done);
			end
		end
	end

	// Receiver: stalls a random number of cycles before each result, once for a long stretch.
	initial begin
		int hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = draw_gap(recv_calm);
			if (squeeze_req && !squeeze_done) begin
				hold         = SQUEEZE_CYCLES;
				squeeze_done = 1'b1;
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if ($urandom_range(0, 99) == 0)
				recv_calm = !recv_calm;
		end
	end

	initial begin
		int                                 n;
		int                                 chunk;
		logic [nirt_pkg::CfgIndexWidth-1:0] idx;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		kind      <= KIND_TICK;
		command   <= 8'h00;
		cfg_we    <= 1'b0;
		cfg_index <= nirt_pkg::REG_ADDRESS_LOW;
		cfg_data  <= '0;
		regs = '{8'h10, 8'h6f, 8'd13, 8'd8, 12'd1125, 12'd562, 12'd70, 12'd210};
		seg_phase   = nirt_pkg::PH_IDLE;
		bit_idx     = 5'd0;
		frame_word  = 32'd0;
		tick_cnt    = 8'd0;
		units_rem   = 12'd0;
		carrier_cnt = 8'd0;
		ir_line     = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A three-unit leader keeps the opening frame short but still in its burst below.
		write_reg(nirt_pkg::REG_LEADER_MARK_UNITS, 12'd3);
		foreach (OPENING[i])
			send_item(OPENING[i].kind, OPENING[i].cmd, OPENING[i].known, OPENING[i].want);

		// Mid-frame writes: zero ticks and counts act as one, addresses wait for the next start.
		write_reg(nirt_pkg::REG_UNIT_TICKS, 12'h000);
		write_reg(nirt_pkg::REG_CARRIER_HALF_TICKS, 12'h000);
		write_reg(nirt_pkg::REG_LEADER_SPACE_UNITS, 12'd0);
		write_reg(nirt_pkg::REG_BIT_MARK_UNITS, 12'd1);
		write_reg(nirt_pkg::REG_ONE_SPACE_UNITS, 12'd2);
		write_reg(nirt_pkg::REG_ADDRESS_LOW, 12'hfff);
		write_reg(nirt_pkg::REG_ADDRESS_HIGH, 12'h000);
		write_reg(REG_SPARE_FIRST, 12'hfff);
		write_reg(REG_SPARE_LAST, 12'h5a5);
		run_out_frame();

		// Widest unit and carrier, cut short mid-burst, then a short leader space.
		write_reg(nirt_pkg::REG_UNIT_TICKS, 12'hfff);
		write_reg(nirt_pkg::REG_CARRIER_HALF_TICKS, 12'h0ff);
		write_reg(nirt_pkg::REG_LEADER_MARK_UNITS, 12'd2);
		write_reg(nirt_pkg::REG_LEADER_SPACE_UNITS, 12'd5);
		send_item(KIND_START, 8'hff, 1'b0, '0);
		send_calm = 1'b1;
		repeat (270) send_item(KIND_TICK, 8'($urandom), 1'b0, '0);
		write_reg(nirt_pkg::REG_UNIT_TICKS, 12'd1);
		write_reg(nirt_pkg::REG_CARRIER_HALF_TICKS, 12'd1);
		write_reg(nirt_pkg::REG_BIT_MARK_UNITS, 12'd0);
		write_reg(nirt_pkg::REG_ONE_SPACE_UNITS, 12'd3);
		write_reg(nirt_pkg::REG_LEADER_MARK_UNITS, 12'hfff);
		run_out_frame();
		send_calm = 1'b0;

		for (idx = nirt_pkg::REG_ADDRESS_LOW; idx <= nirt_pkg::REG_ONE_SPACE_UNITS; idx++)
			write_reg(idx, pick_value(idx));
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			n = $urandom_range(0, 2);
			repeat (n) begin
				idx = 4'($urandom_range(0, 9));
				write_reg(idx, pick_value(idx));
			end
			repeat ($urandom_range(0, 2)) send_item(KIND_TICK, 8'($urandom), 1'b0, '0);
			send_item(KIND_START, 8'($urandom), 1'b0, '0);
			while (seg_phase != nirt_pkg::PH_IDLE) begin
				chunk     = $urandom_range(1, 60);
				send_calm = $urandom_range(0, 3) == 0;
				// First chunk keeps offering items while the receiver holds off.
				if (!squeeze_req) begin
					squeeze_req = 1'b1;
					send_calm   = 1'b1;
					chunk       = 40;
				end
				for (n = 0; n < chunk && seg_phase != nirt_pkg::PH_IDLE; n++)
					send_item(($urandom_range(0, 29) == 0) ? KIND_START : KIND_TICK,
						8'($urandom), 1'b0, '0);
				if (seg_phase != nirt_pkg::PH_IDLE && $urandom_range(0, 3) == 0) begin
					idx = 4'($urandom_range(0, 9));
					write_reg(idx, pick_value(idx));
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d complete frames with %0d refused starts; %0d results checked.",
			frames_sent, starts_rejected, results_seen);
		$display("Made %0d register writes, including zero, widest and unused indexes.",
			reg_writes);
		if (mismatches == 0)
			$display("nec_ir_frame_transmitter test passed");
		else
			$display("nec_ir_frame_transmitter test failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d results still expected.", expected_levels.size());
		$display("nec_ir_frame_transmitter test failed");
		$finish;
	end

endmodule
